// ===== src/ffha_pkg.sv =====
package ffha_pkg;

  localparam int FREE_SLOTS_DEF   = 16;
  localparam int ADDR_BITS_DEF    = 32;
  localparam int WORD_BYTES_DEF   = 8;
  localparam int HEADER_BYTES_DEF = 24;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 31;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 32;

  localparam logic [ADDR_W-1:0] HEAP_START_RST = 32'd4096;
  localparam logic [ADDR_W-1:0] HEAP_END_RST   = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_END   = 1'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_REUSED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GROWN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd5;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

// ===== src/first_fit_heap_allocator.sv =====
// first-fit heap allocator with a bump pointer
// s_* channel: one request per transfer; s_tuser selects allocate (0) or free (1),
// s_tdata carries the request size, the freed block address and its header size.
// m_* channel: exactly one result per request, result address in m_tdata and
// status in m_tuser (reused, grown, freed, null ignored, list full, no space).
// cfg_* channel: register writes (0 heap_start, 1 heap_end), accepted every cycle;
// only to be used while no request is in flight.
// the free list sits in a single-port-write, single-port-read synchronous memory.
// a free goes from acceptance through the done state to its result. an allocate
// passes the quotient and need states, then the scan state (skipped when the list
// is empty), which examines the list newest to oldest with one memory read per
// cycle; a reused block passes the shift state if newer entries must move down
// one slot as it leaves the list, growing the heap or finding no space passes
// the grow state, and both end in the done state. a request is taken only between
// requests; a finished result is parked in the output register, so the next
// request is accepted while the receiver stalls, and its own result waits until
// the output register is free. reset empties the list, unstarts the heap and
// loads the register defaults; no clearing pass is needed.
module first_fit_heap_allocator #(
  parameter int FREE_SLOTS   = ffha_pkg::FREE_SLOTS_DEF,
  parameter int ADDR_BITS    = ffha_pkg::ADDR_BITS_DEF,
  parameter int WORD_BYTES   = ffha_pkg::WORD_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // request_size, block_address, header_size, zero pad
  input  logic [ffha_pkg::S_DATA_W-1:0]    s_tdata,
  // operation
  input  logic [0:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // result_address
  output logic [ffha_pkg::M_DATA_W-1:0]    m_tdata,
  // status
  output logic [ffha_pkg::STATUS_W-1:0]    m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffha_pkg::ADDR_W-1:0]      cfg_data
);

  localparam int IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int MB = (ADDR_BITS > 32) ? 32 : ADDR_BITS;
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << MB) - 64'd1);
  localparam int RSH = 35;
  localparam logic [35:0] RECIP = 36'(((64'd1 << RSH) + WORD_BYTES - 1) / WORD_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QUOT  = 3'd1;
  localparam logic [2:0] S_NEED  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_GROW  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state;
  logic [CW-1:0] count;
  logic [IW-1:0] ptr;
  logic [31:0] heap_top;
  logic        started;
  logic [31:0] heap_start;
  logic [31:0] heap_end;
  logic [30:0] req;
  logic [31:0] quot;
  logic [31:0] need;
  logic [31:0] res_addr;
  logic [ffha_pkg::STATUS_W-1:0] res_status;

  ffha_pkg::entry_t mem [FREE_SLOTS];
  ffha_pkg::entry_t rdata;
  ffha_pkg::entry_t wdata;
  logic          mem_we;
  logic          mem_re;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;

  logic        accept;
  logic        in_op;
  logic [30:0] in_req;
  logic [31:0] in_addr;
  logic [30:0] in_size;
  logic        hit;
  logic        more_above;
  logic [31:0] rnd_x;
  logic [67:0] prod;
  logic [31:0] limit;
  logic [32:0] grow_len;
  logic [32:0] room;
  logic        no_space;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign in_op     = s_tuser[0];
  assign in_req    = s_tdata[30:0];
  assign in_addr   = s_tdata[62:31];
  assign in_size   = s_tdata[93:63];

  assign hit        = ({1'b0, rdata.size} >= need);
  assign more_above = ((CW'(ptr) + CW'(1)) < count);
  assign rnd_x      = {1'b0, req} + 32'(WORD_BYTES - 1);
  assign prod       = {36'd0, rnd_x} * {32'd0, RECIP};
  assign limit      = (heap_end > ADDR_MASK) ? ADDR_MASK : heap_end;
  assign grow_len   = 33'(HEADER_BYTES) + {1'b0, need};
  assign room       = {1'b0, limit} - {1'b0, heap_top};
  assign no_space   = (heap_top > limit) || (room < grow_len);

  always_comb begin
    mem_we = 1'b0;
    waddr  = ptr - IW'(1);
    wdata  = rdata;
    mem_re = 1'b0;
    raddr  = ptr + IW'(1);
    case (state)
      S_IDLE: begin
        waddr = IW'(count);
        wdata = '{addr: in_addr, size: in_size};
        mem_we = accept && (in_op == ffha_pkg::OP_FREE) && (in_addr != '0)
                 && (count < CW'(FREE_SLOTS));
      end
      S_NEED: begin
        mem_re = (count != '0);
        raddr  = IW'(count - CW'(1));
      end
      S_SCAN: begin
        if (hit) begin
          mem_re = more_above;
        end else begin
          mem_re = (ptr != '0);
          raddr  = ptr - IW'(1);
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        mem_re = more_above;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      started    <= 1'b0;
      heap_top   <= '0;
      heap_start <= ffha_pkg::HEAP_START_RST;
      heap_end   <= ffha_pkg::HEAP_END_RST;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ffha_pkg::REG_HEAP_START: heap_start <= cfg_data;
          ffha_pkg::REG_HEAP_END:   heap_end   <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req      <= in_req;
            res_addr <= '0;
            if (in_op == ffha_pkg::OP_ALLOC) begin
              if (!started) begin
                heap_top <= heap_start & ADDR_MASK;
                started  <= 1'b1;
              end
              state <= S_QUOT;
            end else begin
              if (in_addr == '0) begin
                res_status <= ffha_pkg::ST_NULL;
              end else if (count >= CW'(FREE_SLOTS)) begin
                res_status <= ffha_pkg::ST_FULL;
              end else begin
                res_status <= ffha_pkg::ST_FREED;
                count      <= count + CW'(1);
              end
              state <= S_DONE;
            end
          end
        end
        S_QUOT: begin
          quot  <= prod[RSH+31:RSH];
          state <= S_NEED;
        end
        S_NEED: begin
          need <= 32'(quot * 32'(WORD_BYTES));
          ptr  <= IW'(count - CW'(1));
          state <= (count != '0) ? S_SCAN : S_GROW;
        end
        S_SCAN: begin
          if (hit) begin
            res_addr   <= rdata.addr;
            res_status <= ffha_pkg::ST_REUSED;
            if (more_above) begin
              ptr   <= ptr + IW'(1);
              state <= S_SHIFT;
            end else begin
              count <= count - CW'(1);
              state <= S_DONE;
            end
          end else if (ptr == '0) begin
            state <= S_GROW;
          end else begin
            ptr <= ptr - IW'(1);
          end
        end
        S_SHIFT: begin
          if (more_above) begin
            ptr <= ptr + IW'(1);
          end else begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_GROW: begin
          if (no_space) begin
            res_status <= ffha_pkg::ST_NOSPACE;
          end else begin
            res_status <= ffha_pkg::ST_GROWN;
            res_addr   <= heap_top + 32'(HEADER_BYTES);
            heap_top   <= 32'({1'b0, heap_top} + grow_len);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_addr;
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/ffha_checker.sv =====
module ffha_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ffha_pkg::M_DATA_W-1:0] m_tdata,
  input logic [ffha_pkg::STATUS_W-1:0] m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ffha_pkg::ST_NOSPACE)
    else $error("status out of range");

  // only a granted block carries an address, and it is never null
  a_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == ffha_pkg::ST_REUSED || m_tuser == ffha_pkg::ST_GROWN)
                  == (m_tdata != '0)))
    else $error("address and status disagree");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result after reset");

  // a request taken does not show its result in the cycle after it is accepted
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result too early");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
